/* rtl/pte_pkg.sv */
// ----------------------------------------------------------------------------
// pte_pkg: shared definitions for the permutation table engine
// Table geometry, field widths, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package pte_pkg;

	// Table geometry
	localparam int MAX_ENTRIES = 256;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int VAL_W       = 9;
	localparam int CMP_W       = (VAL_W > CNT_W) ? VAL_W : CNT_W;

	// Stream and register port widths
	localparam int IN_DATA_W   = 32;
	localparam int IN_USER_W   = 3;
	localparam int OUT_DATA_W  = 16;
	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 3;

	// Register index, taken from paddr[2]
	localparam logic REG_TABLE_SIZE = 1'b0;
	localparam logic [VAL_W-1:0] TABLE_SIZE_RESET = 9'd1;

	typedef enum logic [2:0] {
		OP_IDENTITY = 3'd0,
		OP_SWAP     = 3'd1,
		OP_LOOKUP   = 3'd2,
		OP_WRITE    = 3'd3,
		OP_INVERT   = 3'd4,
		OP_CHECK    = 3'd5,
		OP_IS_IDENT = 3'd6
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_SW_RB,
		S_SW_WA,
		S_SW_WB,
		S_LK_CAP,
		S_CK_CL,
		S_CK_RD,
		S_CK_SN,
		S_CK_EV,
		S_IV_RD,
		S_IV_WR,
		S_CP_RD,
		S_CP_WR,
		S_ID_RD,
		S_ID_EV,
		S_DONE
	} state_t;

endpackage

/* rtl/pte_ram.sv */
// ----------------------------------------------------------------------------
// pte_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module pte_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write, then register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/permutation_table_engine.sv */
// ----------------------------------------------------------------------------
// permutation_table_engine: 1-based permutation table with a small sequencer
// Identity, swap, lookup, write, in-place invert, validity check and
// identity test, all driven through one read port of the table RAM.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake           | content
//  ---------+-----+---------------------+------------------------------------
//  s_*      | in  | s_tvalid / s_tready | opcode, first, second, entry value
//  m_*      | out | m_tvalid / m_tready | mapped value, result flag
//  APB      | in  | psel/penable/pready | table_size at byte address 0
//
//  Identity, write and the unused opcode finish in decode; lookup reads one
//  entry and swap reads two; identity test and check walk up to n entries
//  (n = active table size), and invert then scatters and copies back. Table
//  entries are read through the single read port of the table RAM; the
//  validity walk also reads the seen marks.
//  Reset: table reads as the identity at once through per-entry valid bits;
//  the seen marks are cleared by a pass over the n active slots at the
//  start of each check and invert. s_tready is high only when idle.
//  A result waits in the output register while m_tready is low.
//
module permutation_table_engine (
	input  logic                              clk,
	input  logic                              arst_n,
	// s_tdata: first_index[8:0], second_index[17:9], entry_value[26:18]
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [pte_pkg::IN_DATA_W-1:0]     s_tdata,
	// s_tuser: opcode[2:0]
	input  logic [pte_pkg::IN_USER_W-1:0]     s_tuser,
	// m_tdata: mapped_value[8:0], result_flag[9]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [pte_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [pte_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [pte_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [pte_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);

	localparam int IDX_W = pte_pkg::IDX_W;
	localparam int CNT_W = pte_pkg::CNT_W;
	localparam int VAL_W = pte_pkg::VAL_W;
	localparam int CMP_W = pte_pkg::CMP_W;
	localparam int MAXN  = pte_pkg::MAX_ENTRIES;

	// Identity value of a slot: slot a holds a+1, kept to the value width
	function automatic logic [VAL_W-1:0] ident_val(input logic [IDX_W-1:0] a);
		ident_val = VAL_W'({1'b0, a} + (IDX_W + 1)'(1));
	endfunction

	// Configuration register
	logic [VAL_W-1:0] table_size_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == pte_pkg::REG_TABLE_SIZE);
	assign prdata = (paddr[2] == pte_pkg::REG_TABLE_SIZE) ?
		pte_pkg::APB_DATA_W'(table_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= pte_pkg::TABLE_SIZE_RESET;
		end else if (cfg_wr) begin
			table_size_q <= pwdata[VAL_W-1:0];
		end
	end

	// Clamp the size into 1..MAX_ENTRIES
	logic [CNT_W-1:0] n_act;
	always_comb begin
		if (table_size_q == '0) begin
			n_act = CNT_W'(1);
		end else if (CMP_W'(table_size_q) > CMP_W'(MAXN)) begin
			n_act = CNT_W'(MAXN);
		end else begin
			n_act = CNT_W'(table_size_q);
		end
	end

	// Sequencer and item registers
	pte_pkg::state_t  state_q, state_d;
	pte_pkg::op_t     op_q;
	logic [VAL_W-1:0] i_q, j_q, v_q;
	logic [CNT_W-1:0] n_q, k_q, k_d;
	logic [VAL_W-1:0] tmp_q, tmp_d;
	logic [VAL_W-1:0] mapped_q, mapped_d;
	logic             flag_q, flag_d;
	logic             in_acc;

	assign s_tready = (state_q == pte_pkg::S_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	// Table RAM, its valid bits and the seen marks RAM
	logic [MAXN-1:0]  pv_q;
	logic [IDX_W-1:0] rd_addr, rd_addr_s1;
	logic             pv_s1;
	logic [VAL_W-1:0] ram_rdata, perm_rd;
	logic             perm_we;
	logic [IDX_W-1:0] perm_waddr;
	logic [VAL_W-1:0] perm_wdata;
	logic             scr_we;
	logic [IDX_W-1:0] scr_waddr;
	logic [VAL_W-1:0] scr_rdata;
	logic             seen_we;
	logic [IDX_W-1:0] seen_waddr;
	logic             seen_rdata;
	logic             id_clear, seen_clear, seen_set;
	logic             out_load;

	pte_ram #(.WIDTH(VAL_W), .DEPTH(MAXN)) u_perm (
		.clk   (clk),
		.we    (perm_we),
		.waddr (perm_waddr),
		.wdata (perm_wdata),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	pte_ram #(.WIDTH(VAL_W), .DEPTH(MAXN)) u_scratch (
		.clk   (clk),
		.we    (scr_we),
		.waddr (scr_waddr),
		.wdata (ident_val(k_q[IDX_W-1:0])),
		.raddr (k_q[IDX_W-1:0]),
		.rdata (scr_rdata)
	);

	// Track the read address alongside the RAM so an unwritten slot reads as identity
	always_ff @(posedge clk) begin
		rd_addr_s1 <= rd_addr;
		pv_s1      <= pv_q[rd_addr];
	end

	assign perm_rd = pv_s1 ? ram_rdata : ident_val(rd_addr_s1);

	// Decoded conditions
	logic             i_ok, j_ok, last, bad_val;
	logic [IDX_W-1:0] i_idx, j_idx, k_idx, v_idx, t_idx;

	assign i_ok    = (i_q != '0) && (CMP_W'(i_q) <= CMP_W'(n_q));
	assign j_ok    = (j_q != '0) && (CMP_W'(j_q) <= CMP_W'(n_q));
	assign i_idx   = IDX_W'(i_q - 1'b1);
	assign j_idx   = IDX_W'(j_q - 1'b1);
	assign k_idx   = k_q[IDX_W-1:0];
	assign v_idx   = IDX_W'(perm_rd - 1'b1);
	assign t_idx   = IDX_W'(tmp_q - 1'b1);
	assign last    = (({1'b0, k_q} + 1'b1) == {1'b0, n_q});
	assign bad_val = (tmp_q == '0) || (CMP_W'(tmp_q) > CMP_W'(n_q)) || seen_rdata;

	// Seen marks: cleared slot by slot, read at the value just fetched
	assign seen_we    = seen_clear || seen_set;
	assign seen_waddr = seen_clear ? k_idx : t_idx;

	pte_ram #(.WIDTH(1), .DEPTH(MAXN)) u_seen (
		.clk   (clk),
		.we    (seen_we),
		.waddr (seen_waddr),
		.wdata (seen_set),
		.raddr (v_idx),
		.rdata (seen_rdata)
	);

	// Next state and strobes
	always_comb begin
		state_d    = state_q;
		k_d        = k_q;
		tmp_d      = tmp_q;
		mapped_d   = mapped_q;
		flag_d     = flag_q;
		rd_addr    = k_idx;
		perm_we    = 1'b0;
		perm_waddr = k_idx;
		perm_wdata = perm_rd;
		scr_we     = 1'b0;
		scr_waddr  = v_idx;
		id_clear   = 1'b0;
		seen_clear = 1'b0;
		seen_set   = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			pte_pkg::S_IDLE: begin
				if (in_acc) begin
					state_d = pte_pkg::S_DECODE;
				end
			end
			pte_pkg::S_DECODE: begin
				mapped_d = '0;
				flag_d   = 1'b0;
				k_d      = '0;
				state_d  = pte_pkg::S_DONE;
				case (op_q)
					pte_pkg::OP_IDENTITY: begin
						id_clear = 1'b1;
					end
					pte_pkg::OP_SWAP: begin
						if (i_ok && j_ok && (i_q != j_q)) begin
							rd_addr = i_idx;
							state_d = pte_pkg::S_SW_RB;
						end
					end
					pte_pkg::OP_LOOKUP: begin
						if (i_ok) begin
							rd_addr = i_idx;
							state_d = pte_pkg::S_LK_CAP;
						end else begin
							mapped_d = i_q;
						end
					end
					pte_pkg::OP_WRITE: begin
						if (i_ok) begin
							perm_we    = 1'b1;
							perm_waddr = i_idx;
							perm_wdata = v_q;
						end
					end
					pte_pkg::OP_INVERT, pte_pkg::OP_CHECK: begin
						state_d = pte_pkg::S_CK_CL;
					end
					pte_pkg::OP_IS_IDENT: begin
						state_d = pte_pkg::S_ID_RD;
					end
					default: begin
						state_d = pte_pkg::S_DONE;
					end
				endcase
			end
			// Swap: hold the first entry, then write both back crossed
			pte_pkg::S_SW_RB: begin
				rd_addr = j_idx;
				tmp_d   = perm_rd;
				state_d = pte_pkg::S_SW_WA;
			end
			pte_pkg::S_SW_WA: begin
				perm_we    = 1'b1;
				perm_waddr = i_idx;
				perm_wdata = perm_rd;
				state_d    = pte_pkg::S_SW_WB;
			end
			pte_pkg::S_SW_WB: begin
				perm_we    = 1'b1;
				perm_waddr = j_idx;
				perm_wdata = tmp_q;
				state_d    = pte_pkg::S_DONE;
			end
			pte_pkg::S_LK_CAP: begin
				mapped_d = perm_rd;
				state_d  = pte_pkg::S_DONE;
			end
			// Clear the seen marks of the slots in use
			pte_pkg::S_CK_CL: begin
				seen_clear = 1'b1;
				if (last) begin
					k_d     = '0;
					state_d = pte_pkg::S_CK_RD;
				end else begin
					k_d     = CNT_W'(k_q + 1'b1);
					state_d = pte_pkg::S_CK_CL;
				end
			end
			// Validity walk: mark each value in the seen marks
			pte_pkg::S_CK_RD: begin
				state_d = pte_pkg::S_CK_SN;
			end
			pte_pkg::S_CK_SN: begin
				tmp_d   = perm_rd;
				state_d = pte_pkg::S_CK_EV;
			end
			pte_pkg::S_CK_EV: begin
				if (bad_val) begin
					id_clear = (op_q == pte_pkg::OP_CHECK);
					state_d  = pte_pkg::S_DONE;
				end else begin
					seen_set = 1'b1;
					if (!last) begin
						k_d     = CNT_W'(k_q + 1'b1);
						state_d = pte_pkg::S_CK_RD;
					end else if (op_q == pte_pkg::OP_CHECK) begin
						flag_d  = 1'b1;
						state_d = pte_pkg::S_DONE;
					end else begin
						k_d     = '0;
						state_d = pte_pkg::S_IV_RD;
					end
				end
			end
			// Invert: scatter positions into scratch, then copy back
			pte_pkg::S_IV_RD: begin
				state_d = pte_pkg::S_IV_WR;
			end
			pte_pkg::S_IV_WR: begin
				scr_we = 1'b1;
				if (last) begin
					k_d     = '0;
					state_d = pte_pkg::S_CP_RD;
				end else begin
					k_d     = CNT_W'(k_q + 1'b1);
					state_d = pte_pkg::S_IV_RD;
				end
			end
			pte_pkg::S_CP_RD: begin
				state_d = pte_pkg::S_CP_WR;
			end
			pte_pkg::S_CP_WR: begin
				perm_we    = 1'b1;
				perm_wdata = scr_rdata;
				if (last) begin
					flag_d  = 1'b1;
					state_d = pte_pkg::S_DONE;
				end else begin
					k_d     = CNT_W'(k_q + 1'b1);
					state_d = pte_pkg::S_CP_RD;
				end
			end
			// Identity test: stop at the first mismatch
			pte_pkg::S_ID_RD: begin
				state_d = pte_pkg::S_ID_EV;
			end
			pte_pkg::S_ID_EV: begin
				if (perm_rd != ident_val(k_idx)) begin
					state_d = pte_pkg::S_DONE;
				end else if (last) begin
					flag_d  = 1'b1;
					state_d = pte_pkg::S_DONE;
				end else begin
					k_d     = CNT_W'(k_q + 1'b1);
					state_d = pte_pkg::S_ID_RD;
				end
			end
			pte_pkg::S_DONE: begin
				if (!m_tvalid || m_tready) begin
					out_load = 1'b1;
					state_d  = pte_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pte_pkg::S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pte_pkg::S_IDLE;
			pv_q    <= '0;
		end else begin
			state_q <= state_d;
			for (int e = 0; e < MAXN; e++) begin
				if (id_clear && (CNT_W'(e) < n_q)) begin
					pv_q[e] <= 1'b0;
				end
			end
			if (perm_we) begin
				pv_q[perm_waddr] <= 1'b1;
			end
		end
	end

	// Item and working registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q <= pte_pkg::op_t'(s_tuser);
			i_q  <= s_tdata[VAL_W-1:0];
			j_q  <= s_tdata[2*VAL_W-1:VAL_W];
			v_q  <= s_tdata[3*VAL_W-1:2*VAL_W];
			n_q  <= n_act;
		end
		k_q      <= k_d;
		tmp_q    <= tmp_d;
		mapped_q <= mapped_d;
		flag_q   <= flag_d;
	end

	// Output register: hold the item until taken
	logic             m_tvalid_q;
	logic [VAL_W-1:0] out_mapped_q;
	logic             out_flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_mapped_q <= mapped_q;
			out_flag_q   <= flag_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(pte_pkg::OUT_DATA_W - VAL_W - 1){1'b0}}, out_flag_q, out_mapped_q};

endmodule

/* rtl/pte_checker.sv */
// ----------------------------------------------------------------------------
// pte_checker: port-level checks for the permutation table engine
// Watches the stream and register ports; bound to the top level below.
// ----------------------------------------------------------------------------
module pte_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// An accepted item closes the input until its work is done
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready straight after an accepted item");

	// A lookup value and a set flag never come together
	a_flag_xor_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[9] && (m_tdata[8:0] != 9'd0)))
		else $error("flag set on a lookup result");

	// A size write reads back at the next edge
	a_size_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && !paddr[2] |=>
			(paddr[2] || (prdata[8:0] == $past(pwdata[8:0]))))
		else $error("table size read back differs from the write");

endmodule

bind permutation_table_engine pte_checker u_pte_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.paddr    (paddr),
	.pwdata   (pwdata),
	.prdata   (prdata)
);

/* test/permutation_table_engine_tb.sv */
// ----------------------------------------------------------------------------
// permutation_table_engine_tb: self-checking bench for the permutation engine
// Drives opcode items through the input stream and size writes through APB.
// A tracker class mirrors the table, predicts each result and compares it,
// field by field, with what the output stream returns. Sender gaps, receiver
// stalls and two long receiver hold-offs are applied.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module permutation_table_engine_tb;

	localparam int VAL_W       = pte_pkg::VAL_W;
	localparam int MAX_ENTRIES = pte_pkg::MAX_ENTRIES;
	localparam int IN_DATA_W   = pte_pkg::IN_DATA_W;
	localparam int IN_USER_W   = pte_pkg::IN_USER_W;
	localparam int OUT_DATA_W  = pte_pkg::OUT_DATA_W;
	localparam int APB_DATA_W  = pte_pkg::APB_DATA_W;
	localparam int APB_ADDR_W  = pte_pkg::APB_ADDR_W;

	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam logic [APB_ADDR_W-1:0] TABLE_SIZE_ADDR = {pte_pkg::REG_TABLE_SIZE, 2'b00};
	localparam int LONG_HOLD   = 400;
	localparam int MAX_GAP     = 20;
	localparam int SLOWEST_OP  = 8 * MAX_ENTRIES + 2;
	localparam int QUIET_LIMIT = 4 * (SLOWEST_OP + LONG_HOLD + MAX_GAP);

	typedef struct packed {
		logic [VAL_W-1:0] mapped_value;
		logic             result_flag;
	} result_t;

	// Mirror of the table with a queue of predicted results
	class perm_tracker;
		logic [VAL_W-1:0] entries [MAX_ENTRIES];
		logic [VAL_W-1:0] table_size;
		result_t          expected_results [$];
		int               failures;

		function new();
			for (int k = 0; k < MAX_ENTRIES; k++)
				entries[k] = VAL_W'(k + 1);
			table_size = pte_pkg::TABLE_SIZE_RESET;
			failures = 0;
		endfunction

		function int active_size();
			if (table_size < 1)
				return 1;
			if (table_size > MAX_ENTRIES)
				return MAX_ENTRIES;
			return table_size;
		endfunction

		function void load_identity(int n);
			for (int k = 1; k <= n; k++)
				entries[k-1] = VAL_W'(k);
		endfunction

		function bit is_permutation(int n);
			bit seen [MAX_ENTRIES];
			int v;
			for (int k = 0; k < MAX_ENTRIES; k++)
				seen[k] = 1'b0;
			for (int k = 0; k < n; k++) begin
				v = entries[k];
				if (v < 1 || v > n)
					return 1'b0;
				if (seen[v-1])
					return 1'b0;
				seen[v-1] = 1'b1;
			end
			return 1'b1;
		endfunction

		function bit is_identity(int n);
			for (int k = 1; k <= n; k++)
				if (entries[k-1] != VAL_W'(k))
					return 1'b0;
			return 1'b1;
		endfunction

		function void log_failure(string what);
			failures++;
			if (failures <= 10)
				$display("[%0t] mismatch: %s", $realtime, what);
		endfunction

		// Apply one accepted item and queue the result it must produce
		function void note_item(logic [2:0] op, logic [VAL_W-1:0] fi, logic [VAL_W-1:0] si,
				logic [VAL_W-1:0] ev);
			result_t          r;
			logic [VAL_W-1:0] scratch [MAX_ENTRIES];
			logic [VAL_W-1:0] held;
			int               n;
			bit               fi_ok, si_ok;
			n = active_size();
			r = '0;
			fi_ok = (fi >= 1) && (fi <= n);
			si_ok = (si >= 1) && (si <= n);
			case (op)
				pte_pkg::OP_IDENTITY: load_identity(n);
				pte_pkg::OP_SWAP: begin
					if (fi_ok && si_ok && fi != si) begin
						held = entries[fi-1];
						entries[fi-1] = entries[si-1];
						entries[si-1] = held;
					end
				end
				pte_pkg::OP_LOOKUP: r.mapped_value = fi_ok ? entries[fi-1] : fi;
				pte_pkg::OP_WRITE: begin
					if (fi_ok)
						entries[fi-1] = ev;
				end
				pte_pkg::OP_INVERT: begin
					if (is_permutation(n)) begin
						for (int k = 1; k <= n; k++)
							scratch[entries[k-1]-1] = VAL_W'(k);
						for (int k = 0; k < n; k++)
							entries[k] = scratch[k];
						r.result_flag = 1'b1;
					end
				end
				pte_pkg::OP_CHECK: begin
					if (is_permutation(n))
						r.result_flag = 1'b1;
					else
						load_identity(n);
				end
				pte_pkg::OP_IS_IDENT: r.result_flag = is_identity(n);
				default: ;
			endcase
			expected_results.push_back(r);
		endfunction

		// Compare one accepted result with the oldest prediction
		function void check_result(logic [VAL_W-1:0] mapped, logic flag);
			result_t want;
			if (expected_results.size() == 0) begin
				log_failure($sformatf("unexpected result mapped=%0d flag=%0b", mapped, flag));
				return;
			end
			want = expected_results.pop_front();
			if (mapped !== want.mapped_value || flag !== want.result_flag)
				log_failure($sformatf("expected mapped=%0d flag=%0b, got mapped=%0d flag=%0b",
					want.mapped_value, want.result_flag, mapped, flag));
		endfunction

		function void close_out();
			if (expected_results.size() != 0) begin
				failures += expected_results.size();
				$display("%0d results never arrived", expected_results.size());
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [IN_USER_W-1:0]  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	perm_tracker tracker = new();

	bit               sender_steady = 1'b0;
	bit               long_hold_pending = 1'b0;
	int               burst_left = 0;
	int               quiet_cycles = 0;
	bit               queued_write = 1'b0;
	logic [VAL_W-1:0] queued_write_pos;
	logic [VAL_W-1:0] queued_write_val;

	permutation_table_engine u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #6 clk = ~clk;

	// Sample both streams and register writes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (psel && penable && pwrite && pready && paddr == TABLE_SIZE_ADDR)
				tracker.table_size = pwdata[VAL_W-1:0];
			if (s_tvalid && s_tready)
				tracker.note_item(s_tuser, s_tdata[8:0], s_tdata[17:9], s_tdata[26:18]);
			if (m_tvalid && m_tready)
				tracker.check_result(m_tdata[8:0], m_tdata[9]);
		end
	end

	// Abort when no item moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Result sink: stall on changing patterns, with a long hold-off on request
	initial begin : result_sink
		int mode;
		int span;
		int tick;
		m_tready = 1'b0;
		tick = 0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(50, 300);
			repeat (span) begin
				@(negedge clk);
				if (long_hold_pending) begin
					m_tready <= 1'b0;
					repeat (LONG_HOLD) @(negedge clk);
					long_hold_pending = 1'b0;
				end
				tick++;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= (tick % 4 == 0);
					default: m_tready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	// Offer one item, pausing between bursts unless the sender is steady, and hold it until accepted
	task automatic send_item(input logic [2:0] op, input logic [VAL_W-1:0] fi,
			input logic [VAL_W-1:0] si, input logic [VAL_W-1:0] ev);
		int gap;
		if (!sender_steady && burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, MAX_GAP) : $urandom_range(1, 4);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= IN_DATA_W'({ev, si, fi});
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
			input logic [APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Stop offering and wait until every predicted result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (tracker.expected_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Pick the next random item, mostly operations that keep a valid table
	task automatic choose_item(output logic [2:0] op, output logic [VAL_W-1:0] fi,
			output logic [VAL_W-1:0] si, output logic [VAL_W-1:0] ev);
		int n;
		int roll;
		n  = tracker.active_size();
		op = 3'($urandom_range(0, 7));
		fi = VAL_W'($urandom_range(0, 511));
		si = VAL_W'($urandom_range(0, 511));
		ev = VAL_W'($urandom_range(0, 511));
		if (queued_write) begin
			// second half of a swap done by two writes
			op = pte_pkg::OP_WRITE;
			fi = queued_write_pos;
			ev = queued_write_val;
			queued_write = 1'b0;
			return;
		end
		roll = $urandom_range(0, 99);
		if (roll < 12) begin
			// noise: leave everything random
		end else if (roll < 40) begin
			op = pte_pkg::OP_SWAP;
			fi = VAL_W'($urandom_range(1, n));
			si = VAL_W'($urandom_range(1, n));
		end else if (roll < 52) begin
			op = pte_pkg::OP_LOOKUP;
			fi = VAL_W'($urandom_range(1, n));
		end else if (roll < 58) begin
			op = pte_pkg::OP_WRITE;
			fi = VAL_W'($urandom_range(1, n));
			si = VAL_W'($urandom_range(1, n));
			ev = tracker.entries[si-1];
			queued_write = 1'b1;
			queued_write_pos = si;
			queued_write_val = tracker.entries[fi-1];
		end else if (roll < 62) begin
			op = pte_pkg::OP_WRITE;
			fi = VAL_W'($urandom_range(1, n));
		end else if (roll < 74) begin
			op = pte_pkg::OP_INVERT;
		end else if (roll < 86) begin
			op = pte_pkg::OP_CHECK;
		end else if (roll < 95) begin
			op = pte_pkg::OP_IS_IDENT;
		end else begin
			op = pte_pkg::OP_IDENTITY;
		end
	endtask

	initial begin : stimulus
		int               sizes [15] = '{0, 2, 3, 4, 8, 13, 256, 16, 300, 6, 511, 31, 1, 64, 9};
		int               count;
		logic [2:0]       op;
		logic [VAL_W-1:0] fi, si, ev;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Table as left by reset, size one
		send_item(pte_pkg::OP_LOOKUP, 9'd1, 9'd0, 9'd0);
		send_item(pte_pkg::OP_LOOKUP, 9'd2, 9'd0, 9'd0);
		send_item(pte_pkg::OP_INVERT, 9'd0, 9'd0, 9'd0);
		send_item(pte_pkg::OP_IS_IDENT, 9'd0, 9'd0, 9'd0);
		drain_results();

		// Directed cases on a five-entry table
		write_register(TABLE_SIZE_ADDR, 32'd5);
		send_item(pte_pkg::OP_SWAP, 9'd1, 9'd5, 9'd0);
		send_item(pte_pkg::OP_SWAP, 9'd2, 9'd2, 9'd0);
		send_item(pte_pkg::OP_SWAP, 9'd0, 9'd3, 9'd0);
		send_item(pte_pkg::OP_SWAP, 9'd3, 9'd6, 9'd0);
		send_item(pte_pkg::OP_SWAP, 9'd511, 9'd511, 9'd511);
		send_item(pte_pkg::OP_LOOKUP, 9'd0, 9'd0, 9'd0);
		send_item(pte_pkg::OP_LOOKUP, 9'd511, 9'd0, 9'd0);
		send_item(pte_pkg::OP_LOOKUP, 9'd5, 9'd0, 9'd0);
		send_item(pte_pkg::OP_IS_IDENT, 9'd0, 9'd0, 9'd0);
		send_item(pte_pkg::OP_INVERT, 9'd0, 9'd0, 9'd0);
		send_item(pte_pkg::OP_CHECK, 9'd0, 9'd0, 9'd0);
		send_item(pte_pkg::OP_WRITE, 9'd0, 9'd0, 9'd511);
		send_item(pte_pkg::OP_WRITE, 9'd6, 9'd0, 9'd1);
		send_item(pte_pkg::OP_WRITE, 9'd2, 9'd0, 9'd511);
		send_item(pte_pkg::OP_INVERT, 9'd0, 9'd0, 9'd0);
		send_item(pte_pkg::OP_LOOKUP, 9'd2, 9'd0, 9'd0);
		send_item(pte_pkg::OP_CHECK, 9'd0, 9'd0, 9'd0);
		send_item(pte_pkg::OP_IS_IDENT, 9'd0, 9'd0, 9'd0);
		send_item(pte_pkg::OP_WRITE, 9'd3, 9'd0, 9'd0);
		send_item(pte_pkg::OP_CHECK, 9'd0, 9'd0, 9'd0);
		send_item(OP_UNUSED, 9'd511, 9'd511, 9'd511);
		send_item(pte_pkg::OP_SWAP, 9'd1, 9'd2, 9'd0);
		send_item(pte_pkg::OP_INVERT, 9'd0, 9'd0, 9'd0);
		send_item(pte_pkg::OP_IDENTITY, 9'd0, 9'd0, 9'd0);

		// Random phases over several table sizes, few items on the large ones
		for (int p = 0; p < 15; p++) begin
			drain_results();
			write_register(TABLE_SIZE_ADDR, APB_DATA_W'(sizes[p]));
			sender_steady = (p % 4 == 3);
			count = (sizes[p] >= 100) ? 30 : 120;
			if (p == 2 || p == 9)
				long_hold_pending = 1'b1;
			repeat (count) begin
				choose_item(op, fi, si, ev);
				send_item(op, fi, si, ev);
			end
		end

		drain_results();
		repeat (SLOWEST_OP + 8) @(negedge clk);
		tracker.close_out();
		if (tracker.failures == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
